// File: src/salru_pkg.sv
package salru_pkg;

   // Request kinds carried on req_type.
   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_STORE  = 2'd1;
   localparam logic [1:0] REQ_MODIFY = 2'd2;
   localparam logic [1:0] REQ_NONE   = 2'd3;

   // Outcome codes of one access.
   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BITS = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [2:0] SET_BITS_RESET    = 3'd4;
   localparam logic [3:0] WAYS_RESET        = 4'd1;
   localparam logic [3:0] OFFSET_BITS_RESET = 4'd4;

   localparam logic [3:0] MAX_OFFSET_BITS = 4'd12;

   localparam int ADDR_PORT_W = 64;
   localparam int STAMP_W     = 64;
   localparam int COUNT_W     = 32;

   typedef logic [STAMP_W-1:0] stamp_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type COUNT_MAX = '1;

   function automatic count_type sat_inc(input count_type value);
      sat_inc = (value == COUNT_MAX) ? value : value + count_type'(1);
   endfunction

endpackage

// File: src/salru_line_mem.sv
module salru_line_mem #(
   parameter int ROW_W  = 8,
   parameter int ADDR_W = 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ROW_W-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ROW_W-1:0]  rd_data
);

   logic [ROW_W-1:0] mem_ff [2**ADDR_W];
   logic [ROW_W-1:0] rd_data_ff;

   // One set per row; the read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/set_assoc_cache_lru_model.sv
// An accepted start reads the set row; S_LOOK looks it up, on an eviction S_SCAN walks the
// stamps of the extra ways, and S_WRITE writes the row back; the result strobe is registered
// from S_WRITE. A modify rereads the row in S_REREAD and looks it up again for its second word.
// No new access is taken until the last one is through. The receiver cannot stall.
// Reset is synchronous and active high; after it the block stays busy while it clears the
// valid bits of every set, one row per cycle.
module set_assoc_cache_lru_model
   import salru_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request side.
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_type,
   input  logic [ADDR_PORT_W-1:0] req_address,
   // Result side, one word per access.
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_outcome,
   output logic [2:0]             rsp_way_used,
   output logic                   rsp_last_of_run,
   output logic [COUNT_W-1:0]     rsp_hit_total,
   output logic [COUNT_W-1:0]     rsp_miss_total,
   output logic [COUNT_W-1:0]     rsp_eviction_total,
   // Configuration writes.
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // The set index port needs at least one bit even with a single set.
   localparam int ROW_BITS = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_BITS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   // Each memory row holds one whole set: every way keeps valid, tag and stamp.
   typedef struct packed {
      logic                  valid;
      logic [ADDR_WIDTH-1:0] tag;
      stamp_type             stamp;
   } entry_type;

   typedef entry_type [MAX_WAYS-1:0] row_type;

   localparam int ROW_W = $bits(row_type);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LOOK   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_WRITE  = 3'd4;
   localparam logic [2:0] S_REREAD = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [ROW_BITS-1:0]   clr_ff, clr_in;

   logic [2:0]            cfg_sets_ff;
   logic [3:0]            cfg_ways_ff;
   logic [3:0]            cfg_offset_ff;

   logic [ROW_BITS-1:0]   set_ff, set_in;
   logic [ADDR_WIDTH-1:0] tag_ff, tag_in;
   logic                  last_ff, last_in;
   row_type               row_ff, row_in;
   logic [1:0]            outcome_ff, outcome_in;
   logic [WAY_BITS-1:0]   pick_ff, pick_in;
   logic [WAY_BITS-1:0]   scan_ff, scan_in;
   stamp_type             best_ff, best_in;

   stamp_type             clock_ff, clock_in;
   count_type             hits_ff, hits_in;
   count_type             misses_ff, misses_in;
   count_type             evicts_ff, evicts_in;

   logic                  strobe_ff, strobe_in;
   logic [1:0]            out_outcome_ff, out_outcome_in;
   logic [2:0]            out_way_ff, out_way_in;
   logic                  out_last_ff, out_last_in;

   // Effective configuration after saturation.
   logic [2:0]            set_bits;
   logic [3:0]            offset_bits;
   logic [3:0]            ways;
   logic [4:0]            tag_shift;
   logic [ADDR_WIDTH-1:0] addr_used;
   logic [ADDR_WIDTH-1:0] addr_shifted;
   logic [ROW_BITS-1:0]   set_mask;
   logic [ROW_BITS-1:0]   set_calc;

   logic                  accept;
   logic                  mem_wr_en;
   logic [ROW_BITS-1:0]   mem_wr_addr;
   row_type               mem_wr_data;
   logic                  mem_rd_en;
   logic [ROW_BITS-1:0]   mem_rd_addr;
   row_type               mem_rd_data;

   logic [MAX_WAYS-1:0]   hit_vec;
   logic [MAX_WAYS-1:0]   free_vec;
   logic [WAY_BITS-1:0]   hit_way;
   logic [WAY_BITS-1:0]   free_way;
   logic [WAY_BITS+2:0]   way_wide;
   stamp_type             stamp_next;
   row_type               row_new;

   salru_line_mem #(
      .ROW_W  (ROW_W),
      .ADDR_W (ROW_BITS)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Oversized settings saturate; zero ways counts as one way.
   always_comb begin
      set_bits    = (32'(cfg_sets_ff) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg_sets_ff;
      offset_bits = (cfg_offset_ff > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : cfg_offset_ff;
      if (cfg_ways_ff == 4'd0) begin
         ways = 4'd1;
      end else if (32'(cfg_ways_ff) > MAX_WAYS) begin
         ways = 4'(MAX_WAYS);
      end else begin
         ways = cfg_ways_ff;
      end
   end

   // Split the address: offset below, set index in the middle, the rest is the tag.
   always_comb begin
      addr_used    = req_address[ADDR_WIDTH-1:0];
      addr_shifted = addr_used >> offset_bits;
      set_mask     = ~({ROW_BITS{1'b1}} << set_bits);
      set_calc     = addr_shifted[ROW_BITS-1:0] & set_mask;
      tag_shift    = 5'(set_bits) + 5'(offset_bits);
   end

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Lookup over the row just read: ways past the configured count are not searched.
   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         hit_vec[w]  = (w < int'(ways)) && mem_rd_data[w].valid &&
                       (mem_rd_data[w].tag == tag_ff);
         free_vec[w] = (w < int'(ways)) && !mem_rd_data[w].valid;
      end
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_BITS'(w);
         end
         if (free_vec[w]) begin
            free_way = WAY_BITS'(w);
         end
      end
   end

   // Updated row for the write-back: the chosen way takes the tag and the new stamp.
   always_comb begin
      stamp_next             = clock_ff + stamp_type'(1);
      row_new                = row_ff;
      row_new[pick_ff].valid = 1'b1;
      row_new[pick_ff].tag   = tag_ff;
      row_new[pick_ff].stamp = stamp_next;
      way_wide               = (WAY_BITS + 3)'(pick_ff);
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      set_in         = set_ff;
      tag_in         = tag_ff;
      last_in        = last_ff;
      row_in         = row_ff;
      outcome_in     = outcome_ff;
      pick_in        = pick_ff;
      scan_in        = scan_ff;
      best_in        = best_ff;
      clock_in       = clock_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      evicts_in      = evicts_ff;
      strobe_in      = 1'b0;
      out_outcome_in = out_outcome_ff;
      out_way_in     = out_way_ff;
      out_last_in    = out_last_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = set_ff;
      mem_wr_data    = row_new;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = set_ff;

      case (state_ff)
         S_CLEAR: begin
            // Zero one row per cycle so that every way starts invalid.
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + ROW_BITS'(1);
            if (clr_ff == {ROW_BITS{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // A REQ_NONE request is taken and dropped without any access.
            if (accept && (req_type != REQ_NONE)) begin
               set_in      = set_calc;
               tag_in      = addr_used >> tag_shift;
               last_in     = (req_type != REQ_MODIFY);
               mem_rd_en   = 1'b1;
               mem_rd_addr = set_calc;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            row_in = mem_rd_data;
            if (|hit_vec) begin
               outcome_in = OUT_HIT;
               pick_in    = hit_way;
               state_in   = S_WRITE;
            end else if (|free_vec) begin
               outcome_in = OUT_FILL;
               pick_in    = free_way;
               state_in   = S_WRITE;
            end else begin
               // Every searched way is valid: find the oldest stamp, lowest way on a tie.
               outcome_in = OUT_EVICT;
               pick_in    = '0;
               best_in    = mem_rd_data[0].stamp;
               scan_in    = WAY_BITS'(1);
               state_in   = (ways == 4'd1) ? S_WRITE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (row_ff[scan_ff].stamp < best_ff) begin
               best_in = row_ff[scan_ff].stamp;
               pick_in = scan_ff;
            end
            if (int'(scan_ff) == int'(ways) - 1) begin
               state_in = S_WRITE;
            end else begin
               scan_in = scan_ff + WAY_BITS'(1);
            end
         end
         S_WRITE: begin
            mem_wr_en = 1'b1;
            clock_in  = stamp_next;
            case (outcome_ff)
               OUT_HIT: begin
                  hits_in = sat_inc(hits_ff);
               end
               OUT_FILL: begin
                  misses_in = sat_inc(misses_ff);
               end
               OUT_EVICT: begin
                  misses_in = sat_inc(misses_ff);
                  evicts_in = sat_inc(evicts_ff);
               end
               default: begin
               end
            endcase
            strobe_in      = 1'b1;
            out_outcome_in = outcome_ff;
            out_way_in     = way_wide[2:0];
            out_last_in    = last_ff;
            // The second access of a modify rereads the row after this write lands.
            state_in       = last_ff ? S_IDLE : S_REREAD;
         end
         S_REREAD: begin
            last_in   = 1'b1;
            mem_rd_en = 1'b1;
            state_in  = S_LOOK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         cfg_sets_ff   <= SET_BITS_RESET;
         cfg_ways_ff   <= WAYS_RESET;
         cfg_offset_ff <= OFFSET_BITS_RESET;
         clock_ff      <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         evicts_ff     <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         clock_ff  <= clock_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         evicts_ff <= evicts_in;
         strobe_ff <= strobe_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_SET_BITS: begin
                  cfg_sets_ff <= csr_wdata[2:0];
               end
               CSR_WAYS: begin
                  cfg_ways_ff <= csr_wdata;
               end
               CSR_OFFSET_BITS: begin
                  cfg_offset_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      set_ff         <= set_in;
      tag_ff         <= tag_in;
      last_ff        <= last_in;
      row_ff         <= row_in;
      outcome_ff     <= outcome_in;
      pick_ff        <= pick_in;
      scan_ff        <= scan_in;
      best_ff        <= best_in;
      out_outcome_ff <= out_outcome_in;
      out_way_ff     <= out_way_in;
      out_last_ff    <= out_last_in;
   end

   // The totals registers already hold the values after the access being reported.
   assign rsp_strobe         = strobe_ff;
   assign rsp_outcome        = out_outcome_ff;
   assign rsp_way_used       = out_way_ff;
   assign rsp_last_of_run    = out_last_ff;
   assign rsp_hit_total      = hits_ff;
   assign rsp_miss_total     = misses_ff;
   assign rsp_eviction_total = evicts_ff;

endmodule

// File: tb/sv/cache_check_pkg.sv
package cache_check_pkg;

   import salru_pkg::*;

   localparam int MODEL_SET_BITS   = 6;
   localparam int MODEL_WAYS       = 8;
   localparam int LINE_TOTAL       = (1 << MODEL_SET_BITS) * MODEL_WAYS;
   localparam int OFFSET_BITS_CAP  = 12;

   typedef struct packed {
      logic [1:0] outcome;
      logic [2:0] way_used;
      logic       last_of_run;
      count_type  hit_total;
      count_type  miss_total;
      count_type  eviction_total;
   } access_word_type;

   // Tag-only shadow of the cache plus the queue of words it still owes.
   class cache_lookup_checker;

      logic [2:0]   set_bits_reg;
      logic [3:0]   ways_reg;
      logic [3:0]   offset_bits_reg;

      bit           line_valid [LINE_TOTAL];
      logic [63:0]  line_tag [LINE_TOTAL];
      stamp_type    line_stamp [LINE_TOTAL];
      stamp_type    access_clock;
      count_type    hit_count;
      count_type    miss_count;
      count_type    evict_count;

      access_word_type owed_words [$];
      int unsigned     failures;

      function new();
         set_bits_reg    = SET_BITS_RESET;
         ways_reg        = WAYS_RESET;
         offset_bits_reg = OFFSET_BITS_RESET;
         for (int i = 0; i < LINE_TOTAL; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_stamp[i] = '0;
         end
         access_clock = '0;
         hit_count    = '0;
         miss_count   = '0;
         evict_count  = '0;
         failures     = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_SET_BITS:    set_bits_reg    = value[2:0];
            CSR_WAYS:        ways_reg        = value;
            CSR_OFFSET_BITS: offset_bits_reg = value;
            default: ;
         endcase
      endfunction

      function int unsigned eff_set_bits();
         return (set_bits_reg > MODEL_SET_BITS) ? MODEL_SET_BITS : int'(set_bits_reg);
      endfunction

      function int unsigned eff_offset_bits();
         return (offset_bits_reg > OFFSET_BITS_CAP) ? OFFSET_BITS_CAP : int'(offset_bits_reg);
      endfunction

      function int unsigned eff_ways();
         if (ways_reg == 0)
            return 1;
         return (ways_reg > MODEL_WAYS) ? MODEL_WAYS : int'(ways_reg);
      endfunction

      function count_type bump_count(count_type value);
         return (value == '1) ? value : value + 1'b1;
      endfunction

      function void predict_lookup(logic [63:0] addr, bit last);
         int unsigned     sbits, obits, nways, base, pick;
         logic [63:0]     set_sel, tag;
         logic [1:0]      outcome;
         bit              found;
         stamp_type       oldest;
         access_word_type word;
         sbits   = eff_set_bits();
         obits   = eff_offset_bits();
         nways   = eff_ways();
         set_sel = (addr >> obits) & ((64'd1 << sbits) - 64'd1);
         tag     = addr >> (sbits + obits);
         base    = int'(set_sel) * MODEL_WAYS;
         access_clock = access_clock + 1'b1;
         found = 1'b0;
         pick  = 0;
         for (int w = 0; w < nways; w++) begin
            if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
               found = 1'b1;
               pick  = w;
            end
         end
         if (found) begin
            outcome   = OUT_HIT;
            hit_count = bump_count(hit_count);
         end else begin
            miss_count = bump_count(miss_count);
            for (int w = 0; w < nways; w++) begin
               if (!found && !line_valid[base + w]) begin
                  found = 1'b1;
                  pick  = w;
               end
            end
            if (found) begin
               outcome = OUT_FILL;
            end else begin
               // Oldest stamp loses; strict compare keeps the lowest way on a tie.
               oldest = line_stamp[base];
               pick   = 0;
               for (int w = 1; w < nways; w++) begin
                  if (line_stamp[base + w] < oldest) begin
                     oldest = line_stamp[base + w];
                     pick   = w;
                  end
               end
               outcome     = OUT_EVICT;
               evict_count = bump_count(evict_count);
            end
            line_valid[base + pick] = 1'b1;
            line_tag[base + pick]   = tag;
         end
         line_stamp[base + pick] = access_clock;
         word.outcome        = outcome;
         word.way_used       = 3'(pick);
         word.last_of_run    = last;
         word.hit_total      = hit_count;
         word.miss_total     = miss_count;
         word.eviction_total = evict_count;
         owed_words.push_back(word);
      endfunction

      function void note_request(logic [1:0] kind, logic [63:0] addr);
         case (kind)
            REQ_LOAD, REQ_STORE: predict_lookup(addr, 1'b1);
            REQ_MODIFY: begin
               predict_lookup(addr, 1'b0);
               predict_lookup(addr, 1'b1);
            end
            default: ;
         endcase
      endfunction

      function bit compare_field(string name, logic [63:0] want, logic [63:0] got,
                                 longint unsigned now);
         if (want !== got) begin
            $display("%0d ns: %s expected %0d, actual %0d", now, name, want, got);
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void check_result(access_word_type got, longint unsigned now);
         access_word_type want;
         bit              bad;
         if (owed_words.size() == 0) begin
            $display("%0d ns: result word with nothing expected, actual outcome %0d way %0d",
                     now, got.outcome, got.way_used);
            failures++;
            return;
         end
         want = owed_words.pop_front();
         bad  = compare_field("rsp_outcome", 64'(want.outcome), 64'(got.outcome), now);
         bad |= compare_field("rsp_way_used", 64'(want.way_used), 64'(got.way_used), now);
         bad |= compare_field("rsp_last_of_run", 64'(want.last_of_run),
                              64'(got.last_of_run), now);
         bad |= compare_field("rsp_hit_total", 64'(want.hit_total), 64'(got.hit_total), now);
         bad |= compare_field("rsp_miss_total", 64'(want.miss_total),
                              64'(got.miss_total), now);
         bad |= compare_field("rsp_eviction_total", 64'(want.eviction_total),
                              64'(got.eviction_total), now);
         if (bad)
            failures++;
      endfunction

      function int pending();
         return owed_words.size();
      endfunction

   endclass

endpackage

// File: tb/sv/tb_top.sv
module tb_top;

   import salru_pkg::*;
   import cache_check_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Phase plan, random part sizing and run limits.
   localparam int PHASES          = 10;
   localparam int WORDS_PER_PHASE = 180;
   // The settle time covers the worst access, a modify whose first lookup evicts, with margin on top.
   localparam int SETTLE_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT  = 2000;

   // Index 3 selects no register; writes to it must leave the block unchanged.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [1:0]             req_type;
   logic [ADDR_PORT_W-1:0] req_address;
   logic                   rsp_strobe;
   logic [1:0]             rsp_outcome;
   logic [2:0]             rsp_way_used;
   logic                   rsp_last_of_run;
   logic [COUNT_W-1:0]     rsp_hit_total;
   logic [COUNT_W-1:0]     rsp_miss_total;
   logic [COUNT_W-1:0]     rsp_eviction_total;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   cache_lookup_checker    sb;
   int unsigned            idle_cycles;
   logic [63:0]            addr_pool [$];

   // Register values per phase. They cover the extremes and the saturating cases:
   // set bits written as 15 and 14 wrap to 7 and 6, ways of 0 and above 8, offsets above 12.
   logic [3:0] set_bits_plan [PHASES] = '{4'd0, 4'd6, 4'd15, 4'd2, 4'd11,
                                          4'd1, 4'd5, 4'd4, 4'd14, 4'd8};
   logic [3:0] ways_plan [PHASES]     = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd4,
                                          4'd8, 4'd3, 4'd2, 4'd6, 4'd9};
   logic [3:0] offset_plan [PHASES]   = '{4'd0, 4'd12, 4'd15, 4'd13, 4'd6,
                                          4'd2, 4'd4, 4'd0, 4'd9, 4'd12};

   set_assoc_cache_lru_model u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_address        (req_address),
      .rsp_strobe         (rsp_strobe),
      .rsp_outcome        (rsp_outcome),
      .rsp_way_used       (rsp_way_used),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always #5ns clock = ~clock;

   // Everything is sampled at the rising edge, so the values seen here are the ones the
   // block saw. The result word is checked before the new request is noted; a result can
   // never belong to a request accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_result('{rsp_outcome, rsp_way_used, rsp_last_of_run, rsp_hit_total,
                              rsp_miss_total, rsp_eviction_total}, $time);
         if (start && !busy)
            sb.note_request(req_type, req_address);
      end
   end

   // The watchdog only counts cycles in which no word moves on either side.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Mostly back to back or short gaps, now and then a long one. A steady phase never idles.
   function automatic int unsigned pick_gap(bit steady);
      int unsigned r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Presents one request word and holds it until the block takes it. With a gap of zero
   // start stays high so the next call can present its word at the very next cycle.
   // While start is low the request ports carry noise, which the block must ignore.
   task automatic send_request(input logic [1:0] kind, input logic [63:0] addr,
                               input int unsigned gap);
      @(negedge clock);
      start       = 1'b1;
      req_type    = kind;
      req_address = addr;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         @(negedge clock);
         start       = 1'b0;
         req_type    = 2'($urandom);
         req_address = {$urandom, $urandom};
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Register writes take effect at the rising edge while csr_write_en is held high.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = index;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      csr_index    = CSR_INDEX_W'($urandom);
      csr_wdata    = CSR_DATA_W'($urandom);
      sb.write_register(index, value);
   endtask

   // Stops issuing, waits for every owed word, then lets the block settle. An ignored
   // request type produces no word, so the settle time also covers one still in flight.
   task automatic wait_for_drain();
      @(negedge clock);
      start = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      int unsigned sbits, obits, nways, issued;
      logic [63:0] set_mask, block_mask, base, addr;
      logic [1:0]  kind;
      bit          steady;

      sb           = new();
      idle_cycles  = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_type     = REQ_LOAD;
      req_address  = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_SET_BITS;
      csr_wdata    = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // The block clears its valid bits one set per cycle before it takes any word.
      wait_for_drain();

      // Directed part under the reset settings: 16 sets, 16-byte blocks, one way.
      send_request(REQ_LOAD, 64'h0, pick_gap(1'b0));                   // fill
      send_request(REQ_STORE, 64'h8, pick_gap(1'b0));                  // hit in the same block
      send_request(REQ_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, pick_gap(1'b0)); // fill, then hit
      send_request(REQ_NONE, 64'h5555_5555_5555_5555, pick_gap(1'b0)); // ignored
      send_request(REQ_LOAD, 64'h100, pick_gap(1'b0));                 // evict in set 0
      send_request(REQ_STORE, 64'h0, pick_gap(1'b0));                  // evict back
      send_request(REQ_MODIFY, 64'h100, pick_gap(1'b0));               // evict, then hit
      send_request(REQ_LOAD, 64'hAAAA_AAAA_AAAA_AAAA, pick_gap(1'b0));
      wait_for_drain();

      // Two ways: fill the empty way, hit, then evict the least recently used one.
      write_csr(CSR_WAYS, 4'd2);
      send_request(REQ_LOAD, 64'h0, pick_gap(1'b0));
      send_request(REQ_LOAD, 64'h100, pick_gap(1'b0));
      send_request(REQ_LOAD, 64'h200, pick_gap(1'b0));
      send_request(REQ_MODIFY, 64'h5555_5555_5555_5550, pick_gap(1'b0));
      send_request(REQ_LOAD, 64'h8000_0000_0000_0000, pick_gap(1'b0));
      send_request(REQ_NONE, 64'hFFFF_FFFF_FFFF_FFFF, pick_gap(1'b0));
      wait_for_drain();

      // Back to one way while lines sit in way 1: those lines are kept but not searched.
      write_csr(CSR_WAYS, 4'd1);
      send_request(REQ_LOAD, 64'h200, pick_gap(1'b0));
      send_request(REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFF0, pick_gap(1'b0));
      send_request(REQ_STORE, 64'h0000_0000_0000_0200, pick_gap(1'b0));
      wait_for_drain();

      // Random phases. Each draws from a small pool of blocks in two sets so that hits,
      // fills and evictions all occur, with a share of fully random addresses mixed in.
      for (int p = 0; p < PHASES; p++) begin
         write_csr(CSR_SET_BITS, set_bits_plan[p]);
         write_csr(CSR_WAYS, ways_plan[p]);
         write_csr(CSR_OFFSET_BITS, offset_plan[p]);
         if (p == 3)
            write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));

         sbits      = sb.eff_set_bits();
         obits      = sb.eff_offset_bits();
         nways      = sb.eff_ways();
         set_mask   = ((64'd1 << sbits) - 64'd1) << obits;
         block_mask = (64'd1 << obits) - 64'd1;
         addr_pool.delete();
         repeat (3 * nways + 3) begin
            base = {$urandom, $urandom};
            base = (base & ~set_mask & ~block_mask)
                   | ((64'($urandom_range(0, 1)) << obits) & set_mask);
            addr_pool.push_back(base);
         end

         steady = ($urandom_range(0, 3) == 0);
         issued = 0;
         while (issued < WORDS_PER_PHASE) begin
            kind = ($urandom_range(0, 99) < 4) ? REQ_NONE : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 99) < 20)
               addr = {$urandom, $urandom};
            else
               addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)]
                      | ({$urandom, $urandom} & block_mask);
            send_request(kind, addr, pick_gap(steady));
            if (kind != REQ_NONE)
               issued++;
         end
         wait_for_drain();
      end

      if (sb.failures == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: set_assoc_cache_lru_model.f
src/salru_pkg.sv
src/salru_line_mem.sv
src/set_assoc_cache_lru_model.sv
tb/sv/cache_check_pkg.sv
tb/sv/tb_top.sv
